[rtl/wildcard_star_pattern_matcher_unit_assert.svh]
// Assertion macros for the wildcard star pattern matcher.
// Included by the top level; no other dependencies.
`ifndef WILDCARD_STAR_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define WILDCARD_STAR_PATTERN_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define WSP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WSP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSP_ASSERT(name, clk, rst_n, prop, msg)
`define WSP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[rtl/wsp_pkg.sv]
// Shared constants and types of the wildcard star pattern matcher.
// No dependencies; used by wsp_step and the top level.
package wsp_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
    localparam int CFG_W       = 5;
    localparam int OP_W        = 2;
    localparam int ELEM_IDX_W  = 4;
    localparam int CHAR_W      = 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_TEXT  = 2'd2
    } op_t;

    typedef struct packed {
        logic              star;
        logic              wild;
        logic [CHAR_W-1:0] ch;
    } elem_t;

    typedef struct packed {
        logic full_match;
        logic still_alive;
    } result_t;

endpackage

[rtl/wsp_step.sv]
// Next active-position set and match result for one begin or text beat.
// Depends on wsp_pkg.
module wsp_step (
    input  logic [wsp_pkg::OP_W-1:0]                  op,
    input  logic [wsp_pkg::CHAR_W-1:0]                text_char,
    input  wsp_pkg::elem_t [wsp_pkg::PATTERN_MAX-1:0] pattern,
    input  logic [wsp_pkg::CFG_W-1:0]                 count,
    input  logic [wsp_pkg::POS_W-1:0]                 active,
    output logic [wsp_pkg::POS_W-1:0]                 active_next,
    output wsp_pkg::result_t                          result
);
    import wsp_pkg::*;

    logic [CNT_W-1:0]       n;
    logic [POS_W-1:0]       pass;
    logic [POS_W-1:0]       in_use;
    logic [PATTERN_MAX-1:0] stay;
    logic [PATTERN_MAX-1:0] go;
    logic [POS_W-1:0]       start_closed;
    logic [POS_W-1:0]       pre_closed;
    logic [POS_W-1:0]       advanced;
    logic [POS_W-1:0]       post_closed;
    logic [POS_W-1:0]       final_set;

    // Parallel-prefix closure across runs of star elements.
    function automatic logic [POS_W-1:0] close_set(
        input logic [POS_W-1:0] a,
        input logic [POS_W-1:0] p_in
    );
        logic [POS_W-1:0] g;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] g_old;
        logic [POS_W-1:0] p_old;
        g = a;
        p = p_in;
        for (int d = 1; d < POS_W; d = d * 2) begin
            g_old = g;
            p_old = p;
            for (int j = 0; j < POS_W; j++) begin
                if (j >= d) begin
                    g[j] = g_old[j] | (p_old[j] & g_old[j-d]);
                    p[j] = p_old[j] & p_old[j-d];
                end
            end
        end
        return g;
    endfunction

    always_comb begin
        n = (32'(count) > PATTERN_MAX) ? CNT_W'(PATTERN_MAX) : CNT_W'(count);
        pass = '0;
        for (int j = 1; j < POS_W; j++) begin
            pass[j] = pattern[j-1].star && ((j - 1) < 32'(n));
        end
        for (int j = 0; j < POS_W; j++) begin
            in_use[j] = (j <= 32'(n));
        end
    end

    always_comb begin
        start_closed = close_set(POS_W'(1), pass);
        pre_closed   = close_set(active, pass);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            logic hit;
            hit = pre_closed[i] && (i < 32'(n))
                  && (pattern[i].wild || (pattern[i].ch == text_char));
            stay[i] = hit && pattern[i].star;
            go[i]   = hit && !pattern[i].star;
        end
        advanced    = {1'b0, stay} | {go, 1'b0};
        post_closed = close_set(advanced, pass);
    end

    always_comb begin
        case (op)
            OP_BEGIN: final_set = start_closed;
            OP_TEXT:  final_set = post_closed;
            default:  final_set = active;
        endcase
        active_next        = final_set;
        result.full_match  = final_set[n];
        result.still_alive = |(final_set & in_use);
    end

endmodule

[rtl/wildcard_star_pattern_matcher_unit.sv]
// Top level of the wildcard star pattern matcher: input register, pattern
// table, active-position register and result register.
// Depends on wsp_pkg, wsp_step and the assertion macro header.
//
//   port group   dir   handshake         carries
//   s_*          in    s_valid/s_ready   load, begin or text beat
//   cfg_*        in    cfg_valid/ready   pattern element count
//   m_*          out   m_valid/m_ready   full_match, still_alive
//
// One beat per cycle unless m_ready stalls; results are held in result_reg.
// Text beats close, advance and close the active set; begin closes position 0.
// Synchronous active-low reset clears the active set, count and valid flags.
// m_ready low holds the result, then the input register, then drops s_ready.
`include "wildcard_star_pattern_matcher_unit_assert.svh"

module wildcard_star_pattern_matcher_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [wsp_pkg::OP_W-1:0]         s_opcode,
    input  logic [wsp_pkg::ELEM_IDX_W-1:0]   s_element_index,
    input  logic [wsp_pkg::CHAR_W-1:0]       s_element_char,
    input  logic                             s_element_wild,
    input  logic                             s_element_star,
    input  logic [wsp_pkg::CHAR_W-1:0]       s_text_char,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wsp_pkg::CFG_W-1:0]        cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_full_match,
    output logic                             m_still_alive
);
    import wsp_pkg::*;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [OP_W-1:0]         in_op_reg;
    logic [ELEM_IDX_W-1:0]   in_index_reg;
    elem_t                   in_elem_reg;
    logic [CHAR_W-1:0]       in_text_reg;
    elem_t [PATTERN_MAX-1:0] pattern_reg;
    logic [CFG_W-1:0]        count_reg;
    logic [POS_W-1:0]        active_reg;
    logic [POS_W-1:0]        active_next;
    logic [POS_W-1:0]        step_active;
    result_t                 step_result;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    result_t                 result_reg;
    logic                    out_free;
    logic                    fire;
    logic                    emits;
    logic                    loads;

    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign emits     = fire && ((in_op_reg == OP_BEGIN) || (in_op_reg == OP_TEXT));
    assign loads     = fire && (in_op_reg == OP_LOAD);

    wsp_step u_step (
        .op          (in_op_reg),
        .text_char   (in_text_reg),
        .pattern     (pattern_reg),
        .count       (count_reg),
        .active      (active_reg),
        .active_next (step_active),
        .result      (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        active_next  = fire ? step_active : active_reg;
        m_valid_next = m_valid_reg;
        if (emits) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            active_reg   <= '0;
            count_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            active_reg   <= active_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg        <= s_opcode;
            in_index_reg     <= s_element_index;
            in_elem_reg.ch   <= s_element_char;
            in_elem_reg.wild <= s_element_wild;
            in_elem_reg.star <= s_element_star;
            in_text_reg      <= s_text_char;
        end
        if (emits) begin
            result_reg <= step_result;
        end
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (loads && (in_index_reg == ELEM_IDX_W'(j))) begin
                pattern_reg[j] <= in_elem_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_full_match  = result_reg.full_match;
    assign m_still_alive = result_reg.still_alive;

    `WSP_ASSERT(a_emit_shows, aclk, aresetn, emits |=> m_valid, "result beat not presented")
    `WSP_ASSERT(a_match_alive, aclk, aresetn, m_valid |-> (!m_full_match || m_still_alive), "full match without live position")
    `WSP_ASSERT(a_load_keeps, aclk, aresetn, loads |=> $stable(active_reg), "load beat changed active set")
    `WSP_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (!m_valid && (active_reg == '0)), "reset did not clear state")

endmodule
